// ===== hdl/amgs_pkg.sv =====
// Shared types and constants for the adjacency matrix graph store.
package amgs_pkg;

   localparam int VERT_W = 3;              // vertex number width
   localparam int CNT_W  = 7;              // edge count width
   localparam int ACT_W  = 3;              // command code width
   localparam logic [CNT_W-1:0] MAX_EDGES = 7'd64;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD      = 3'd0,
      ACT_TEST     = 3'd1,
      ACT_LIST_OUT = 3'd2,
      ACT_LIST_IN  = 3'd3,
      ACT_LIST_ALL = 3'd4,
      ACT_CLEAR    = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MIRROR,
      ST_SCAN,
      ST_RESP
   } state_type;

   // one access to the bit matrix
   typedef struct packed {
      logic              set_bit;
      logic              count;
      logic              clear_all;
      logic [VERT_W-1:0] row;
      logic [VERT_W-1:0] col;
   } mat_ctrl_type;

endpackage

// ===== hdl/amgs_matrix.sv =====
// Edge bit matrix with single-bit probe/set port and edge counter.
module amgs_matrix #(
   parameter int VERTICES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  amgs_pkg::mat_ctrl_type     ctrl,
   output logic                       hit,
   output logic [amgs_pkg::CNT_W-1:0] edge_count
);
   import amgs_pkg::*;

   localparam int IW = $clog2(VERTICES);

   logic [VERTICES-1:0] rows_ff [VERTICES];
   logic [CNT_W-1:0]    count_ff;
   logic                in_range;
   logic [IW-1:0]       row_idx;
   logic [IW-1:0]       col_idx;

   assign in_range   = (int'(ctrl.row) < VERTICES) && (int'(ctrl.col) < VERTICES);
   assign row_idx    = ctrl.row[IW-1:0];
   assign col_idx    = ctrl.col[IW-1:0];
   assign hit        = in_range && rows_ff[row_idx][col_idx];
   assign edge_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_all) begin
         for (int i = 0; i < VERTICES; i++) begin
            rows_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (ctrl.set_bit && in_range) begin
         rows_ff[row_idx][col_idx] <= 1'b1;
         // only a new, counted bit bumps the total
         if (ctrl.count && !rows_ff[row_idx][col_idx] && count_ff < MAX_EDGES) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

endmodule

// ===== hdl/adjacency_matrix_graph_store.sv =====
// Adjacency matrix graph store: command sequencer around a one-bit-per-cycle matrix probe.
//
//   channel  | direction | handshake          | word
//   req_     | in        | valid / stall      | action, from_vertex, to_vertex
//   rsp_     | out       | valid / stall      | edge_from, edge_to, present, edge_total, last
//   csr_     | in        | valid / ready      | directed
//
// The matrix probe looks at one bit per cycle unless a stalled response word holds the
// scan, which sets the listing length. Reset (synchronous) empties the matrix, zeroes
// the count and selects undirected mode. req_stall stays high from acceptance until
// the last response word is in the output register; a stalled response word holds its
// payload.
module adjacency_matrix_graph_store #(
   parameter int VERTICES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [amgs_pkg::ACT_W-1:0]  req_action,
   input  logic [amgs_pkg::VERT_W-1:0] req_from_vertex,
   input  logic [amgs_pkg::VERT_W-1:0] req_to_vertex,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [amgs_pkg::VERT_W-1:0] rsp_edge_from,
   output logic [amgs_pkg::VERT_W-1:0] rsp_edge_to,
   output logic                        rsp_present,
   output logic [amgs_pkg::CNT_W-1:0]  rsp_edge_total,
   output logic                        rsp_last,
   // register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_directed
);
   import amgs_pkg::*;

   localparam int IW = $clog2(VERTICES);
   localparam logic [IW-1:0] LAST_IDX = IW'(VERTICES - 1);

   // sequencer state
   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [VERT_W-1:0] u_ff, u_in;
   logic [VERT_W-1:0] v_ff, v_in;
   logic              directed_ff;

   // scan position
   logic [IW-1:0]     r_ff, r_in;
   logic [IW-1:0]     c_ff, c_in;

   // pending result word (held back one find so the last mark is known)
   logic [VERT_W-1:0] res_from_ff, res_from_in;
   logic [VERT_W-1:0] res_to_ff, res_to_in;
   logic              res_present_ff, res_present_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VERT_W-1:0] rsp_from_ff;
   logic [VERT_W-1:0] rsp_to_ff;
   logic              rsp_present_ff;
   logic [CNT_W-1:0]  rsp_total_ff;
   logic              rsp_last_ff;

   mat_ctrl_type      mat_ctrl;
   logic              hit;
   logic [CNT_W-1:0]  edge_count;

   logic              u_ok, v_ok;
   logic              out_free;
   logic              scan_end;
   logic              need_out;
   logic              scan_hold;
   logic              emit;
   logic              emit_last;

   amgs_matrix #(
      .VERTICES (VERTICES)
   ) u_matrix (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mat_ctrl),
      .hit        (hit),
      .edge_count (edge_count)
   );

   assign u_ok      = int'(u_ff) < VERTICES;
   assign v_ok      = int'(v_ff) < VERTICES;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a find while another is pending pushes the pending one out
   assign need_out  = hit && res_present_ff;
   assign scan_hold = need_out && !out_free;

   always_comb begin
      unique case (act_ff)
         ACT_LIST_OUT: scan_end = (c_ff == LAST_IDX);
         ACT_LIST_IN:  scan_end = (r_ff == LAST_IDX);
         default:      scan_end = (c_ff == LAST_IDX) && (r_ff == LAST_IDX);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (act_ff)
               ACT_ADD:      state_in = (u_ok && v_ok && !directed_ff) ? ST_MIRROR : ST_RESP;
               ACT_LIST_OUT: state_in = u_ok ? ST_SCAN : ST_RESP;
               ACT_LIST_IN:  state_in = v_ok ? ST_SCAN : ST_RESP;
               ACT_LIST_ALL: state_in = ST_SCAN;
               default:      state_in = ST_RESP;
            endcase
         end
         ST_MIRROR: state_in = ST_RESP;
         ST_SCAN: begin
            if (!scan_hold && scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      act_in         = act_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      res_from_in    = res_from_ff;
      res_to_in      = res_to_ff;
      res_present_in = res_present_ff;
      mat_ctrl       = '{set_bit: 1'b0, count: 1'b0, clear_all: 1'b0, row: u_ff, col: v_ff};
      emit           = 1'b0;
      emit_last      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in = action_type'(req_action);
               u_in   = req_from_vertex;
               v_in   = req_to_vertex;
            end
         end
         ST_EXEC: begin
            // default answer echoes the query with nothing found
            res_from_in    = u_ff;
            res_to_in      = v_ff;
            res_present_in = 1'b0;
            unique case (act_ff)
               ACT_ADD: begin
                  mat_ctrl.set_bit = u_ok && v_ok;
                  mat_ctrl.count   = 1'b1;
                  res_present_in   = u_ok && v_ok;
               end
               ACT_TEST: begin
                  res_present_in = hit;
               end
               ACT_LIST_OUT: begin
                  r_in = u_ff[IW-1:0];
                  c_in = '0;
               end
               ACT_LIST_IN: begin
                  r_in = '0;
                  c_in = v_ff[IW-1:0];
               end
               ACT_LIST_ALL: begin
                  r_in = '0;
                  c_in = '0;
               end
               ACT_CLEAR: begin
                  mat_ctrl.clear_all = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_MIRROR: begin
            // mirror bit of an undirected add, never counted
            mat_ctrl.set_bit = 1'b1;
            mat_ctrl.row     = v_ff;
            mat_ctrl.col     = u_ff;
         end
         ST_SCAN: begin
            mat_ctrl.row = VERT_W'(r_ff);
            mat_ctrl.col = VERT_W'(c_ff);
            if (!scan_hold) begin
               emit = need_out;
               if (hit) begin
                  res_from_in    = VERT_W'(r_ff);
                  res_to_in      = VERT_W'(c_ff);
                  res_present_in = 1'b1;
               end
               if (!scan_end) begin
                  unique case (act_ff)
                     ACT_LIST_OUT: c_in = c_ff + IW'(1);
                     ACT_LIST_IN:  r_in = r_ff + IW'(1);
                     default: begin
                        if (c_ff == LAST_IDX) begin
                           c_in = '0;
                           r_in = r_ff + IW'(1);
                        end else begin
                           c_in = c_ff + IW'(1);
                        end
                     end
                  endcase
               end
            end
         end
         ST_RESP: begin
            emit      = out_free;
            emit_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         directed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            directed_ff <= csr_directed;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      u_ff           <= u_in;
      v_ff           <= v_in;
      r_ff           <= r_in;
      c_ff           <= c_in;
      res_from_ff    <= res_from_in;
      res_to_ff      <= res_to_in;
      res_present_ff <= res_present_in;
      if (emit) begin
         rsp_from_ff    <= res_from_ff;
         rsp_to_ff      <= res_to_ff;
         rsp_present_ff <= res_present_ff;
         rsp_total_ff   <= edge_count;
         rsp_last_ff    <= emit_last;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_from  = rsp_from_ff;
   assign rsp_edge_to    = rsp_to_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_edge_total = rsp_total_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== hdl/amgs_checker.sv =====
// Port-level checks for the graph store, bound to the top level.
module amgs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_present,
   input logic [amgs_pkg::CNT_W-1:0]  rsp_edge_total,
   input logic                        rsp_last
);
   import amgs_pkg::*;

   // a held word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   // an accepted command keeps the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command port not stalled after accept");

   // nothing-found words always close their command
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_last)
      else $error("word without edge lacks last mark");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_edge_total <= MAX_EDGES)
      else $error("edge total beyond matrix size");

   // the command port reopens only as the final word goes out
   a_release_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) && !$past(reset) |-> rsp_valid && rsp_last)
      else $error("command port reopened before last word");

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (.*);

// ===== tb/amgs_graph_checker.sv =====
// Response checker for the adjacency matrix graph store: tracks the graph and compares words.
module amgs_graph_checker
   import amgs_pkg::*;
#(
   parameter int VERTICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [VERT_W-1:0] req_from_vertex,
   input  logic [VERT_W-1:0] req_to_vertex,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [VERT_W-1:0] rsp_edge_from,
   input  logic [VERT_W-1:0] rsp_edge_to,
   input  logic              rsp_present,
   input  logic [CNT_W-1:0]  rsp_edge_total,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_directed,
   output int                fail_count,
   output int                words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [VERT_W-1:0] src;
      logic [VERT_W-1:0] dst;
      logic              present;
      logic [CNT_W-1:0]  total;
      logic              last;
   } edge_report_type;

   logic [7:0]       adj_rows [8];
   logic [CNT_W-1:0] edge_count;
   logic             dir_mode;
   edge_report_type  edge_reports [$];

   function automatic edge_report_type report(input logic [VERT_W-1:0] src,
                                              input logic [VERT_W-1:0] dst,
                                              input logic present, input logic last);
      edge_report_type w;
      w.src     = src;
      w.dst     = dst;
      w.present = present;
      w.total   = edge_count;
      w.last    = last;
      return w;
   endfunction

   // append one word to the tail of the expected stream
   task automatic queue_report(input edge_report_type w);
      edge_reports.insert(edge_reports.size(), w);
   endtask

   function automatic int field_differs(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // update the tracked graph for one command and queue the words it should produce
   task automatic graph_command(input logic [ACT_W-1:0] act,
                                input logic [VERT_W-1:0] u, input logic [VERT_W-1:0] v);
      int              found;
      logic            hit;
      edge_report_type tail;
      found = 0;
      unique case (act)
         ACT_ADD: begin
            if (u < VERTICES && v < VERTICES) begin
               if (!adj_rows[u][v]) begin
                  adj_rows[u][v] = 1'b1;
                  if (edge_count < MAX_EDGES) edge_count++;
               end
               // mirror bit is set but never counted
               if (!dir_mode) adj_rows[v][u] = 1'b1;
               queue_report(report(u, v, 1'b1, 1'b1));
            end else begin
               queue_report(report(u, v, 1'b0, 1'b1));
            end
         end
         ACT_TEST: begin
            hit = (u < VERTICES && v < VERTICES) ? adj_rows[u][v] : 1'b0;
            queue_report(report(u, v, hit, 1'b1));
         end
         ACT_LIST_OUT, ACT_LIST_IN, ACT_LIST_ALL: begin
            for (int r = 0; r < VERTICES; r++) begin
               for (int c = 0; c < VERTICES; c++) begin
                  if (act == ACT_LIST_OUT && r != u) continue;
                  if (act == ACT_LIST_IN && c != v) continue;
                  if (adj_rows[r][c] && found < 64) begin
                     queue_report(report(VERT_W'(r), VERT_W'(c), 1'b1, 1'b0));
                     found++;
                  end
               end
            end
            if (found == 0) begin
               queue_report(report(u, v, 1'b0, 1'b1));
            end else begin
               tail = edge_reports.pop_back();
               tail.last = 1'b1;
               queue_report(tail);
            end
         end
         ACT_CLEAR: begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            edge_count = '0;
            queue_report(report(u, v, 1'b0, 1'b1));
         end
         default: queue_report(report(u, v, 1'b0, 1'b1));
      endcase
   endtask

   always @(posedge clock) begin
      edge_report_type want;
      int              bad;
      if (reset) begin
         foreach (adj_rows[i]) adj_rows[i] = '0;
         edge_count = '0;
         dir_mode   = 1'b0;
         edge_reports.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) dir_mode = csr_directed;
         if (rsp_valid && !rsp_stall) begin
            if (edge_reports.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual from %0d to %0d last %0d",
                        $time, rsp_edge_from, rsp_edge_to, rsp_last);
               fail_count++;
            end else begin
               want = edge_reports.pop_front();
               bad  = field_differs("edge_from", want.src, rsp_edge_from)
                    + field_differs("edge_to", want.dst, rsp_edge_to)
                    + field_differs("present", want.present, rsp_present)
                    + field_differs("edge_total", want.total, rsp_edge_total)
                    + field_differs("last", want.last, rsp_last);
               if (bad != 0) fail_count++;
            end
         end
         if (req_valid && !req_stall)
            graph_command(req_action, req_from_vertex, req_to_vertex);
      end
      words_due = edge_reports.size();
   end

endmodule

// ===== tb/tb_adjacency_matrix_graph_store.sv =====
// Testbench top for the adjacency matrix graph store: stimulus, stalls and verdict.
module tb_adjacency_matrix_graph_store;
   import amgs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VERTICES     = 8;
   localparam int LIMIT_CYCLES = 1_000_000;
   // longest quiet stretch of the block: a full matrix scan plus pipeline
   localparam int DRAIN_CYCLES = VERTICES * VERTICES + 8;
   localparam int CSR_SETTLE   = 8;
   // codes with no command behind them; block must echo and report nothing
   localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ACT_W-1:0]  req_action = ACT_TEST;
   logic [VERT_W-1:0] req_from_vertex = '0;
   logic [VERT_W-1:0] req_to_vertex = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [VERT_W-1:0] rsp_edge_from;
   logic [VERT_W-1:0] rsp_edge_to;
   logic              rsp_present;
   logic [CNT_W-1:0]  rsp_edge_total;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_directed = 1'b0;

   int fail_count;
   int words_due;
   int cycle_count = 0;
   int rsp_hold = 0;
   // per-phase switches that turn off idling on one side or both
   bit quiet_send = 1'b0;
   bit quiet_recv = 1'b0;

   always #5 clock = ~clock;

   adjacency_matrix_graph_store #(
      .VERTICES(VERTICES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_edge_from(rsp_edge_from),
      .rsp_edge_to(rsp_edge_to),
      .rsp_present(rsp_present),
      .rsp_edge_total(rsp_edge_total),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_directed(csr_directed)
   );

   amgs_graph_checker #(
      .VERTICES(VERTICES)
   ) graph_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_edge_from(rsp_edge_from),
      .rsp_edge_to(rsp_edge_to),
      .rsp_present(rsp_present),
      .rsp_edge_total(rsp_edge_total),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_directed(csr_directed),
      .fail_count(fail_count),
      .words_due(words_due)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: after each accepted word, draw a random hold and keep stall up until it runs out
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold = quiet_recv ? 0 : $urandom_range(0, 6);
         rsp_hold  <= hold;
         rsp_stall <= (hold != 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   // one command word; valid stays up when the next word follows with no gap
   task automatic send_command(input logic [ACT_W-1:0] act,
                               input logic [VERT_W-1:0] u, input logic [VERT_W-1:0] v);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_from_vertex <= u;
      req_to_vertex   <= v;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and let every outstanding word come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   // direction switch only with the block fully drained
   task automatic write_directed(input logic mode);
      wait_idle();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_directed <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly adds and queries, with enough listings to scan what was built
   task automatic send_random_command();
      int               pick;
      logic [ACT_W-1:0] act;
      pick = $urandom_range(0, 99);
      if (pick < 40)      act = ACT_ADD;
      else if (pick < 60) act = ACT_TEST;
      else if (pick < 72) act = ACT_LIST_OUT;
      else if (pick < 84) act = ACT_LIST_IN;
      else if (pick < 92) act = ACT_LIST_ALL;
      else if (pick < 95) act = ACT_CLEAR;
      else if (pick < 97) act = ACT_UNDEF_LO;
      else                act = ACT_UNDEF_HI;
      send_command(act, VERT_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 7)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // undirected after reset: empty listings, self loops, mirrors, repeats
      send_command(ACT_LIST_ALL, 3'd5, 3'd2);
      send_command(ACT_TEST, 3'd0, 3'd0);
      send_command(ACT_ADD, 3'd0, 3'd0);
      send_command(ACT_ADD, 3'd7, 3'd7);
      send_command(ACT_ADD, 3'd0, 3'd7);
      send_command(ACT_ADD, 3'd0, 3'd7);
      send_command(ACT_ADD, 3'd7, 3'd0);
      send_command(ACT_TEST, 3'd7, 3'd0);
      send_command(ACT_LIST_OUT, 3'd0, 3'd3);
      send_command(ACT_LIST_IN, 3'd4, 3'd7);
      send_command(ACT_LIST_ALL, 3'd1, 3'd1);
      send_command(ACT_UNDEF_LO, 3'd3, 3'd4);
      send_command(ACT_UNDEF_HI, 3'd7, 3'd0);
      send_command(ACT_CLEAR, 3'd5, 3'd6);
      send_command(ACT_LIST_OUT, 3'd3, 3'd0);
      send_command(ACT_LIST_IN, 3'd0, 3'd3);

      // directed: no mirror, then the reverse edge counts on its own
      write_directed(1'b1);
      send_command(ACT_ADD, 3'd2, 3'd5);
      send_command(ACT_TEST, 3'd5, 3'd2);
      send_command(ACT_LIST_ALL, 3'd0, 3'd0);
      send_command(ACT_ADD, 3'd5, 3'd2);
      send_command(ACT_LIST_IN, 3'd6, 3'd2);

      // full matrix: count reaches 64 and a full scan returns every entry
      for (int r = 0; r < VERTICES; r++)
         for (int c = 0; c < VERTICES; c++)
            send_command(ACT_ADD, VERT_W'(r), VERT_W'(c));
      send_command(ACT_LIST_ALL, 3'd7, 3'd7);
      send_command(ACT_TEST, 3'd7, 3'd7);
      send_command(ACT_CLEAR, 3'd0, 3'd0);

      // random phases over both directions; phases 1 and 2 drop idling on one or both sides
      for (int p = 0; p < 4; p++) begin
         write_directed(p[0]);
         quiet_send = (p == 2);
         quiet_recv = (p == 1 || p == 2);
         for (int k = 0; k < 43; k++) begin
            send_random_command();
            if ($urandom_range(0, 29) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== adjacency_matrix_graph_store.f =====
hdl/amgs_pkg.sv
hdl/amgs_matrix.sv
hdl/adjacency_matrix_graph_store.sv
hdl/amgs_checker.sv
tb/amgs_graph_checker.sv
tb/tb_adjacency_matrix_graph_store.sv
